// ===== rtl/core/cvf_pkg.sv =====
package cvf_pkg;

   // Width of one channel sample and of one wrapped result.
   localparam int SAMPLE_W = 8;
   // Channels carried on the ports, whatever the number of lanes built.
   localparam int PORT_CHANNELS = 4;
   // Results that the output queue can hold.
   localparam int FIFO_DEPTH = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_0_TO_7 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_8_TO_15 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_16_TO_23 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_24 = 3'd6;

   // Control that follows a result down the arithmetic pipeline.
   typedef struct packed {
      logic res;
      logic eor;
      logic eof;
   } cvf_ctrl_type;

endpackage

// ===== rtl/core/conv5x5_zero_padded_filter.sv =====
// Streaming 2D convolution with zero padding. Pixels enter in raster order, one
// transaction per clock, each carrying up to four 8-bit channels; for every pixel
// and channel in use the block returns the low byte of the sum of tap times
// neighbour over a KERNEL_SIZE square centred on the pixel, with neighbours
// outside the image counted as zero. A 5x5 signed kernel is programmed through
// the CSR port and sits centred in the window. Each result trails its input by
// KERNEL_SIZE/2 rows plus KERNEL_SIZE/2 pixels, so that many flush transactions
// (is_flush set) after the last pixel drain the image. The block sustains one
// input transaction per clock while req_stall is low: the line buffer is a
// single-port-read memory of MAX_WIDTH entries that is read and written once per
// pixel, and the channel lanes each complete all taps in parallel. A result passes
// the line buffer read, the window, the lane's product and row-sum registers and
// the output queue before the response port offers it; up to eight results
// wait while rsp_stall is high; req_stall rises only when that queue could fill.
// The line buffer needs no clearing after reset. CSR writes are taken on any
// clock and belong between frames or while the block is idle.
module conv5x5_zero_padded_filter
   import cvf_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_sample_ch0,
   input  logic [7:0]             req_sample_ch1,
   input  logic [7:0]             req_sample_ch2,
   input  logic [7:0]             req_sample_ch3,
   input  logic                   req_is_flush,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_result_ch0,
   output logic [7:0]             rsp_result_ch1,
   output logic [7:0]             rsp_result_ch2,
   output logic [7:0]             rsp_result_ch3,
   output logic                   rsp_end_of_row,
   output logic                   rsp_end_of_frame,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int HALF = KERNEL_SIZE / 2;
   localparam int KK = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LW = SAMPLE_W * MAX_CHANNELS;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > 12) ? WW : 12;
   localparam int DW = $clog2(HALF * MAX_WIDTH + HALF + 1);

   // Configuration registers.
   logic [11:0]           image_width_ff;
   logic [15:0]           image_height_ff;
   logic [2:0]            channel_count_ff;
   logic [3*64-1:0]       taps_ff;
   logic [7:0]            tap_24_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 12'd640;
         image_height_ff <= 16'd480;
         channel_count_ff <= 3'd1;
         taps_ff <= '0;
         tap_24_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[15:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[2:0];
            CSR_TAPS_0_TO_7: taps_ff[63:0] <= csr_wdata;
            CSR_TAPS_8_TO_15: taps_ff[127:64] <= csr_wdata;
            CSR_TAPS_16_TO_23: taps_ff[191:128] <= csr_wdata;
            CSR_TAP_24: tap_24_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // The 5x5 kernel sits centred in the window; window places beyond it use a
   // zero tap, and a 3x3 window uses the centre of the kernel.
   logic [KK-1:0][SAMPLE_W-1:0] tap_vec;
   logic [25*8-1:0]             taps_all;

   assign taps_all = {tap_24_ff, taps_ff};

   for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_tap_row
      for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_tap_col
         localparam int TI = i - HALF + 2;
         localparam int TJ = j - HALF + 2;
         if (TI >= 0 && TI <= 4 && TJ >= 0 && TJ <= 4) begin : g_in
            assign tap_vec[i*KERNEL_SIZE+j] = taps_all[8*(TI*5+TJ) +: 8];
         end else begin : g_out
            assign tap_vec[i*KERNEL_SIZE+j] = '0;
         end
      end
   end

   // Position counters. Input and output counters advance per transaction, and
   // the prime count holds back results until the window reaches the first pixel.
   logic [XW-1:0]  in_col_ff, in_col_in;
   logic [DW-1:0]  prime_ff, prime_in;
   logic [XW-1:0]  out_col_ff, out_col_in;
   logic [15:0]    out_row_ff, out_row_in;
   logic [WW-1:0]  w_eff;
   logic [15:0]    h_eff;
   logic [DW-1:0]  delay;
   logic           produce, in_last, eor, eof, accept, room;
   logic [KERNEL_SIZE-1:0] row_ok, col_ok;
   logic [MAX_CHANNELS-1:0] lane_en;
   logic [LW-1:0]  pix;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (CMPW'(image_width_ff) > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? 16'd1 : image_height_ff;
      delay = DW'(w_eff) * DW'(HALF) + DW'(HALF);
      produce = prime_ff >= delay;
      in_last = (WW'(in_col_ff) + WW'(1)) >= w_eff;
      eor = (WW'(out_col_ff) + WW'(1)) >= w_eff;
      eof = eor && ((17'(out_row_ff) + 17'd1) >= 17'(h_eff));
   end

   // Rows and columns of the window that fall inside the image.
   for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_bounds
      if (i < HALF) begin : g_before
         assign row_ok[i] = 17'(out_row_ff) >= 17'(HALF - i);
         assign col_ok[i] = (WW + 1)'(out_col_ff) >= (WW + 1)'(HALF - i);
      end else begin : g_after
         assign row_ok[i] = (17'(out_row_ff) + 17'(i - HALF)) < 17'(h_eff);
         assign col_ok[i] = ((WW + 1)'(out_col_ff) + (WW + 1)'(i - HALF))
                            < (WW + 1)'(w_eff);
      end
   end

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane_en
      assign lane_en[c] = 3'(c) < channel_count_ff;
   end

   // A flush transaction stores a zero pixel.
   always_comb begin
      pix = '0;
      if (!req_is_flush) begin
         pix = LW'({req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0});
      end
   end

   assign req_stall = !room;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_col_in = in_last ? '0 : in_col_ff + XW'(1);
      prime_in = produce ? prime_ff : prime_ff + DW'(1);
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (produce) begin
         if (eof) begin
            in_col_in = '0;
            prime_in = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (eor) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 16'd1;
         end else begin
            out_col_in = out_col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         prime_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff <= in_col_in;
         prime_ff <= prime_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Stage one: the line buffer read for this column is under way.
   logic                    s1_item_ff;
   cvf_ctrl_type            s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   logic [LW-1:0]           s1_pix_ff;
   logic [XW-1:0]           s1_addr_ff;
   logic [KERNEL_SIZE-1:0]  s1_row_ff, s1_col_ff, s2_row_ff, s2_col_ff;
   logic [MAX_CHANNELS-1:0] s1_lane_ff, s2_lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff <= 1'b0;
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         s4_ctrl_ff <= '0;
      end else begin
         s1_item_ff <= accept;
         s1_ctrl_ff <= '{res: accept && produce, eor: eor, eof: eof};
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
         s4_ctrl_ff <= s3_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= pix;
      s1_addr_ff <= in_col_ff;
      s1_row_ff <= row_ok;
      s1_col_ff <= col_ok;
      s1_lane_ff <= lane_en;
      s2_row_ff <= s1_row_ff;
      s2_col_ff <= s1_col_ff;
      s2_lane_ff <= s1_lane_ff;
   end

   // The line buffer holds, per column, the pixels of the KERNEL_SIZE-1 rows
   // above the current one; each transaction pushes its pixel in at the bottom.
   logic [(KERNEL_SIZE-1)*LW-1:0] lb_rd, lb_wr;
   logic [KERNEL_SIZE-1:0][LW-1:0] colvec;

   always_comb begin
      colvec[0] = s1_pix_ff;
      for (int m = 1; m < KERNEL_SIZE; m++) begin
         colvec[m] = lb_rd[(m-1)*LW +: LW];
      end
      for (int m = 0; m < KERNEL_SIZE - 1; m++) begin
         lb_wr[m*LW +: LW] = colvec[m];
      end
   end

   cvf_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH),
      .DATA_W    ((KERNEL_SIZE - 1) * LW)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .wr_en   (s1_item_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   // Stage two: the window of the last KERNEL_SIZE columns; entry zero is newest.
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][LW-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (s1_item_ff) begin
         window_ff[0] <= colvec;
         for (int k = 1; k < KERNEL_SIZE; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // Channel lanes, each working through all taps at once.
   logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] lane_res;

   for (genvar c = 0; c < PORT_CHANNELS; c++) begin : g_lane
      if (c < MAX_CHANNELS) begin : g_on
         logic [KK-1:0][SAMPLE_W-1:0] smp;
         logic [KK-1:0]               mask;
         for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_i
            for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_j
               assign smp[i*KERNEL_SIZE+j] =
                  window_ff[KERNEL_SIZE-1-j][KERNEL_SIZE-1-i][c*SAMPLE_W +: SAMPLE_W];
               assign mask[i*KERNEL_SIZE+j] = s2_row_ff[i] && s2_col_ff[j] && s2_lane_ff[c];
            end
         end
         cvf_lane #(
            .KERNEL_SIZE (KERNEL_SIZE)
         ) u_lane (
            .clock  (clock),
            .smp    (smp),
            .taps   (tap_vec),
            .mask   (mask),
            .result (lane_res[c])
         );
      end else begin : g_off
         assign lane_res[c] = '0;
      end
   end

   // Merging stage: the lanes' sums and the row and frame marks join in the queue.
   logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] out_res;
   logic pop;

   assign pop = rsp_valid && !rsp_stall;

   cvf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_res  (lane_res),
      .ctrl      (s4_ctrl_ff),
      .admit     (accept && produce),
      .pop       (pop),
      .room      (room),
      .out_valid (rsp_valid),
      .out_res   (out_res),
      .out_eor   (rsp_end_of_row),
      .out_eof   (rsp_end_of_frame)
   );

   assign rsp_result_ch0 = out_res[0];
   assign rsp_result_ch1 = out_res[1];
   assign rsp_result_ch2 = out_res[2];
   assign rsp_result_ch3 = out_res[3];

endmodule

// ===== rtl/core/cvf_line_buffer.sv =====
module cvf_line_buffer
   import cvf_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int DATA_W = 128
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]            wr_data,
   output logic [DATA_W-1:0]            rd_data
);

   logic [DATA_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [DATA_W-1:0] rd_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              byp_ff;

   // A read that meets a write to the same column in the same cycle takes the new data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= line_mem_ff[rd_addr];
         byp_ff <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

// ===== rtl/core/cvf_lane.sv =====
module cvf_lane
   import cvf_pkg::*;
#(
   parameter int KERNEL_SIZE = 5
) (
   input  logic                                              clock,
   input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][SAMPLE_W-1:0] smp,
   input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][SAMPLE_W-1:0] taps,
   input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0]               mask,
   output logic [SAMPLE_W-1:0]                               result
);

   localparam int KK = KERNEL_SIZE * KERNEL_SIZE;

   logic [KK-1:0][SAMPLE_W-1:0]          prod_ff;
   logic [KERNEL_SIZE-1:0][SAMPLE_W-1:0] row_in;
   logic [KERNEL_SIZE-1:0][SAMPLE_W-1:0] row_ff;

   // Only the low byte of each product survives the wrapped sum.
   for (genvar n = 0; n < KK; n++) begin : g_prod
      always_ff @(posedge clock) begin
         prod_ff[n] <= mask[n] ? SAMPLE_W'(taps[n] * smp[n]) : '0;
      end
   end

   always_comb begin
      row_in = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            row_in[i] = row_in[i] + prod_ff[i*KERNEL_SIZE+j];
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_comb begin
      result = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         result = result + row_ff[i];
      end
   end

endmodule

// ===== rtl/core/cvf_merge.sv =====
module cvf_merge
   import cvf_pkg::*;
(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] lane_res,
   input  cvf_ctrl_type                            ctrl,
   input  logic                                    admit,
   input  logic                                    pop,
   output logic                                    room,
   output logic                                    out_valid,
   output logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] out_res,
   output logic                                    out_eor,
   output logic                                    out_eof
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] res;
      logic                                    eor;
      logic                                    eof;
   } cvf_entry_type;

   cvf_entry_type          queue_ff [FIFO_DEPTH];
   logic [PW-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          pending_ff, pending_in;

   // Pending counts results promised to the input side and not yet taken,
   // so the queue can never overflow while the pipeline runs freely.
   always_comb begin
      pending_in = pending_ff + CW'(admit) - CW'(pop);
      count_in = count_ff + CW'(ctrl.res) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         pending_ff <= '0;
      end else begin
         count_ff <= count_in;
         pending_ff <= pending_in;
         if (ctrl.res) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.res) begin
         queue_ff[wr_ptr_ff] <= '{res: lane_res, eor: ctrl.eor, eof: ctrl.eof};
      end
   end

   assign room = pending_ff < CW'(FIFO_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_res = queue_ff[rd_ptr_ff].res;
   assign out_eor = queue_ff[rd_ptr_ff].eor;
   assign out_eof = queue_ff[rd_ptr_ff].eof;

endmodule
